### rtl/pcrc_pkg.sv
// Shared types and constants for the programmable serial CRC block.
`timescale 1ns / 1ps

package pcrc_pkg;

   // Largest generator degree, and so the width of the remainder
   localparam int MAX_DEGREE  = 32;
   localparam int REM_W       = MAX_DEGREE;
   localparam int REM_IDX_W   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int DEG_W       = 6;
   localparam int POLY_W      = 32;
   localparam int CRC_W       = 32;

   // Register file port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_DEGREE   = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_POLY_LOW = CSR_INDEX_W'(2);

   // Operating mode
   typedef enum logic {
      MODE_GENERATE = 1'b0,
      MODE_CHECK    = 1'b1
   } mode_type;

   // Live configuration, handed to the datapath as one group
   typedef struct packed {
      mode_type            mode;
      logic [DEG_W-1:0]    degree;
      logic [POLY_W-1:0]   poly_low;
   } cfg_type;

   // Input beat
   typedef struct packed {
      logic data_bit;
      logic last;
   } req_beat_type;

   // Result beat
   typedef struct packed {
      logic [CRC_W-1:0] crc_value;
      logic             remainder_zero;
      logic             generator_ok;
   } rsp_beat_type;

endpackage

### rtl/pcrc_step.sv
// One-bit LFSR update of the CRC remainder and the generator criteria check.
`timescale 1ns / 1ps

module pcrc_step (
   input  pcrc_pkg::cfg_type               cfg,
   input  logic [pcrc_pkg::REM_W-1:0]      rem,
   input  logic                            data_bit,
   output logic [pcrc_pkg::REM_W-1:0]      rem_next,
   output logic                            generator_ok
);
   import pcrc_pkg::*;

   logic [DEG_W-1:0]     eff_deg;
   logic [REM_IDX_W-1:0] top_idx;
   logic [REM_W-1:0]     mask;
   logic [REM_W-1:0]     poly_m;
   logic [REM_W-1:0]     shifted;
   logic                 top;
   logic                 fb;

   // Clamp degree into 1..MAX_DEGREE
   always_comb begin
      if (cfg.degree == '0) begin
         eff_deg = DEG_W'(1);
      end else if (cfg.degree > DEG_W'(MAX_DEGREE)) begin
         eff_deg = DEG_W'(MAX_DEGREE);
      end else begin
         eff_deg = cfg.degree;
      end
   end

   assign top_idx = REM_IDX_W'(eff_deg - DEG_W'(1));

   // Bits below the effective degree
   always_comb begin
      for (int i = 0; i < REM_W; i++) begin
         mask[i] = (DEG_W'(i) < eff_deg);
      end
   end

   assign poly_m = cfg.poly_low[REM_W-1:0] & mask;
   assign top    = rem[top_idx];

   // Generate shifts in zero and feeds the data bit back; check shifts the bit in
   always_comb begin
      if (cfg.mode == MODE_GENERATE) begin
         shifted = {rem[REM_W-2:0], 1'b0} & mask;
         fb      = top ^ data_bit;
      end else begin
         shifted = {rem[REM_W-2:0], data_bit} & mask;
         fb      = top;
      end
      rem_next = shifted ^ (fb ? poly_m : '0);
   end

   // Odd ones below the implied leading one means an even total: divisible by x+1
   assign generator_ok = poly_m[0] & (^poly_m);

endmodule

### rtl/programmable_crc_generate_check_top.sv
// Top level of the programmable serial CRC generator and checker.
`timescale 1ns / 1ps
//
// Bits of a message enter on the req_ channel, one beat per bit, first bit
// first; req_data.last marks the final bit. Only the beat with last set makes
// a result on the rsp_ channel: the remainder, a zero flag and a flag for the
// generator criteria. The remainder is then cleared for the next message.
// csr_ writes set mode, degree and polynomial into registers, with no wait
// for a message boundary. Throughput: one bit per cycle while no last beat
// waits on a stalled result; the remainder update is a feedback loop through
// one register (one shift, one tap select, one XOR). A last beat enters the
// input register when accepted, then the result register, raising rsp_valid.
// The receiver may stall at will: the result register holds its beat, and
// input beats without last keep flowing. A second last beat waits in the
// input register, and only then is req_stall raised.
// Reset (synchronous) empties both registers, clears the remainder and
// restores mode generate, degree 3, polynomial 1.

module programmable_crc_generate_check_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pcrc_pkg::req_beat_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pcrc_pkg::rsp_beat_type              rsp_data,
   input  logic                                csr_we,
   input  logic [pcrc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pcrc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pcrc_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             in_valid_ff, in_valid_in;
   req_beat_type     in_beat_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_beat_type     out_beat_ff;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W-1:0] rem_next;
   logic             generator_ok;
   logic             req_take;
   logic             advance;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MODE:     cfg_in.mode     = mode_type'(csr_wdata[0]);
            CSR_DEGREE:   cfg_in.degree   = csr_wdata[DEG_W-1:0];
            CSR_POLY_LOW: cfg_in.poly_low = csr_wdata[POLY_W-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode     <= MODE_GENERATE;
         cfg_ff.degree   <= DEG_W'(3);
         cfg_ff.poly_low <= POLY_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Flow control: a last beat moves on only if the result register can take it
   assign advance   = in_valid_ff & (~in_beat_ff.last | ~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = (advance & in_beat_ff.last) | (out_valid_ff & rsp_stall);

   // Remainder datapath
   pcrc_step u_step (
      .cfg          (cfg_ff),
      .rem          (rem_ff),
      .data_bit     (in_beat_ff.data_bit),
      .rem_next     (rem_next),
      .generator_ok (generator_ok)
   );

   always_comb begin
      rem_in = rem_ff;
      if (advance) begin
         rem_in = in_beat_ff.last ? '0 : rem_next;
      end
   end

   // Control and remainder state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rem_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         rem_ff       <= rem_in;
      end
   end

   // Input beat register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_beat_ff <= req_data;
      end
   end

   // Result beat register
   always_ff @(posedge clock) begin
      if (advance & in_beat_ff.last) begin
         out_beat_ff.crc_value      <= CRC_W'(rem_next);
         out_beat_ff.remainder_zero <= (rem_next == '0);
         out_beat_ff.generator_ok   <= generator_ok;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_beat_ff;

endmodule

### rtl/pcrc_checker.sv
// Port-level checks for the programmable CRC top level, bound onto it.
`timescale 1ns / 1ps

module pcrc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input pcrc_pkg::req_beat_type              req_data,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input pcrc_pkg::rsp_beat_type              rsp_data
);
   import pcrc_pkg::*;

   // A held result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // Zero flag agrees with the remainder
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.remainder_zero == (rsp_data.crc_value == '0))
      else $error("zero flag disagrees with remainder");

   // A fresh result follows a last beat that was accepted and passed the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_data.last, 2))
      else $error("result without a last beat");

   // Input is never held off while the result side is empty
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

endmodule

bind programmable_crc_generate_check_top pcrc_checker u_pcrc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
